/* rtl/pme_pkg.sv */
// Package: shared constants for the PIC16 instruction executor.
`default_nettype none
package pme_pkg;
  localparam logic [7:0] STATUS_RST = 8'h18;
  localparam logic [6:0] A_INDF   = 7'h00;
  localparam logic [6:0] A_PCL    = 7'h02;
  localparam logic [6:0] A_STATUS = 7'h03;
  localparam logic [6:0] A_FSR    = 7'h04;
  localparam logic [6:0] A_PCLATH = 7'h0A;
  localparam logic [6:0] A_INTCON = 7'h0B;
endpackage
`default_nettype wire

/* rtl/pme_if.sv */
// Interfaces: valid/ready channels for instruction and result items.
`default_nettype none
interface pme_in_if;
  logic        valid;
  logic        ready;
  logic [13:0] instruction;
  modport source (output valid, output instruction, input ready);
  modport sink (input valid, input instruction, output ready);
endinterface

interface pme_out_if;
  logic        valid;
  logic        ready;
  logic [12:0] next_pc;
  logic [7:0]  w_value;
  logic [7:0]  status_value;
  modport source (output valid, output next_pc, output w_value, output status_value,
                  input ready);
  modport sink (input valid, input next_pc, input w_value, input status_value,
                output ready);
endinterface
`default_nettype wire

/* rtl/pic16_midrange_instruction_executor_core.sv */
// Top level: PIC16 mid-range instruction executor core.
// The accepted instruction and its data store read are registered, then execute registers the result.
// A new instruction is not taken while one executes, set by the data store read-modify-write.
// A new instruction is taken only if the output register is empty or its result leaves.
// Reset: W, FSR, PCLATH, INTCON, PC, stack pointer cleared, STATUS 0x18.
// Data store and return stack use per-entry valid bits; an invalid entry reads zero.
`default_nettype none
module pic16_midrange_instruction_executor_core
  import pme_pkg::*;
#(
  parameter int STACK_DEPTH = 8,
  parameter int DATA_LIMIT  = 208
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  pme_in_if.sink     in_if,
  pme_out_if.source  out_if
);
  localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic [7:0]  mem [256];
  logic [255:0] mvld_q;
  logic [12:0] stk [STACK_DEPTH];
  logic [STACK_DEPTH-1:0] svld_q;

  logic [7:0]  w_q, status_q, fsr_q, intcon_q;
  logic [4:0]  pclath_q;
  logic [12:0] pc_q;
  logic [SW-1:0] sp_q;

  logic        ex_q;
  logic [13:0] ins_q;
  logic [7:0]  addr_q, rd_q;
  logic        rdv_q;
  logic        ov_q;
  logic [12:0] opc_q;
  logic [7:0]  ow_q, ost_q;

  // accept when not executing and output slot frees by execute time
  assign in_if.ready = !ex_q && (!ov_q || out_if.ready);
  wire acc = in_if.valid && in_if.ready;

  // address resolution on incoming instruction, uses current state
  logic [7:0] ra;
  always_comb begin
    logic [6:0] f;
    logic [8:0] bsum;
    f = in_if.instruction[6:0];
    bsum = {2'b0, f} + (status_q[5] ? 9'h080 : 9'h000);
    if (f == 7'd0) ra = fsr_q;
    else if (bsum >= 9'(DATA_LIMIT)) ra = {1'b0, f};
    else ra = {status_q[5], f};
  end

  // execute
  logic [7:0]  w_d, st_d, fsr_d, ic_d, wv, x;
  logic [4:0]  pl_d;
  logic [12:0] pc_d, tgt;
  logic [SW-1:0] sp_d;
  logic        wr, push, jmp, pclw, skip;
  logic [12:0] pop;
  always_comb begin
    logic [5:0] op;
    logic [7:0] k, w, m, r;
    logic [8:0] s;
    logic [4:0] h;
    logic       dd;
    op = ins_q[13:8]; k = ins_q[7:0]; dd = ins_q[7]; w = w_q;
    case (addr_q[6:0])
      A_INDF:   x = 8'd0;
      A_PCL:    x = pc_q[7:0];
      A_STATUS: x = status_q;
      A_FSR:    x = fsr_q;
      A_PCLATH: x = {3'b0, pclath_q};
      A_INTCON: x = intcon_q;
      default:  x = rdv_q ? rd_q : 8'd0;
    endcase
    pop = svld_q[sp_q] ? stk[sp_q] : 13'd0;
    w_d = w_q; st_d = status_q; fsr_d = fsr_q; ic_d = intcon_q; pl_d = pclath_q;
    sp_d = sp_q; wr = 1'b0; wv = 8'd0; push = 1'b0; jmp = 1'b0; tgt = 13'd0;
    skip = 1'b0; m = 8'd1 << ins_q[9:7]; r = x; s = 9'd0; h = 5'd0;
    if (op <= 6'h01) begin
      if (op == 6'h00) begin
        if (dd) begin wr = 1'b1; wv = w_q; end
        else if (ins_q == 14'h0008 || ins_q == 14'h0009) begin
          if (ins_q[0]) ic_d[7] = 1'b1;
          jmp = 1'b1; tgt = pop;
          if (sp_q != '0) sp_d = sp_q - 1'b1;
        end
      end else if (dd) begin
        // CLRF of STATUS loads the reset value and then still sets Z
        wr = 1'b1; wv = (addr_q[6:0] == A_STATUS) ? (STATUS_RST | 8'h04) : 8'd0;
        st_d[2] = 1'b1;
      end else begin
        w_d = 8'd0; st_d[2] = 1'b1;
      end
    end else if (op <= 6'h0F) begin
      case (op[3:0])
        4'h2: begin
          h = {1'b0, x[3:0]} + {1'b0, ~w[3:0]} + 5'd1;
          s = {1'b0, x} + {1'b0, ~w} + 9'd1;
          st_d[1] = h[4]; st_d[0] = s[8]; r = s[7:0]; st_d[2] = (r == 0);
        end
        4'h3: begin r = x - 8'd1; st_d[2] = (r == 0); end
        4'h4: begin r = x | w; st_d[2] = (r == 0); end
        4'h5: begin r = x & w; st_d[2] = (r == 0); end
        4'h6: begin r = x ^ w; st_d[2] = (r == 0); end
        4'h7: begin
          h = {1'b0, x[3:0]} + {1'b0, w[3:0]};
          s = {1'b0, x} + {1'b0, w};
          st_d[1] = h[4]; st_d[0] = s[8]; r = s[7:0]; st_d[2] = (r == 0);
        end
        4'h8: begin r = x; st_d[2] = (r == 0); end
        4'h9: begin r = ~x; st_d[2] = (r == 0); end
        4'hA: begin r = x + 8'd1; st_d[2] = (r == 0); end
        4'hB: begin r = x - 8'd1; skip = (r == 0); end
        4'hC: begin st_d[0] = x[0]; r = {status_q[0], x[7:1]}; end
        4'hD: begin st_d[0] = x[7]; r = {x[6:0], status_q[0]}; end
        4'hE: r = {x[3:0], x[7:4]};
        default: begin r = x + 8'd1; skip = (r == 0); end
      endcase
      if (dd) begin wr = 1'b1; wv = r; end
      else w_d = r;
    end else if (op <= 6'h1F) begin
      case (ins_q[11:10])
        2'd0: begin wr = 1'b1; wv = x & ~m; end
        2'd1: begin wr = 1'b1; wv = x | m; end
        2'd2: skip = ((x & m) == 0);
        default: skip = ((x & m) != 0);
      endcase
    end else if (op <= 6'h2F) begin
      jmp = 1'b1; tgt = {pclath_q[4:3], ins_q[10:0]};
      if (op <= 6'h27) begin
        push = 1'b1;
        sp_d = (32'(sp_q) + 1 >= STACK_DEPTH) ? '0 : sp_q + 1'b1;
      end
    end else begin
      if (op <= 6'h33) w_d = k;
      else if (op <= 6'h37) begin
        w_d = k; jmp = 1'b1; tgt = pop;
        if (sp_q != '0) sp_d = sp_q - 1'b1;
      end else if (op <= 6'h3A) begin
        r = (op == 6'h38) ? (w | k) : (op == 6'h39) ? (w & k) : (w ^ k);
        w_d = r; st_d[2] = (r == 0);
      end else if (op == 6'h3C || op == 6'h3D) begin
        h = {1'b0, k[3:0]} + {1'b0, ~w[3:0]} + 5'd1;
        s = {1'b0, k} + {1'b0, ~w} + 9'd1;
        st_d[1] = h[4]; st_d[0] = s[8]; w_d = s[7:0]; st_d[2] = (s[7:0] == 0);
      end else if (op >= 6'h3E) begin
        h = {1'b0, k[3:0]} + {1'b0, w[3:0]};
        s = {1'b0, k} + {1'b0, w};
        st_d[1] = h[4]; st_d[0] = s[8]; w_d = s[7:0]; st_d[2] = (s[7:0] == 0);
      end
    end
    // file write side effects on special registers
    pclw = 1'b0;
    if (wr) begin
      case (addr_q[6:0])
        A_PCL:    pclw = 1'b1;
        A_STATUS: st_d = wv;
        A_FSR:    fsr_d = wv;
        A_PCLATH: pl_d = wv[4:0];
        A_INTCON: ic_d = wv;
        default:  ;
      endcase
    end
    if (jmp) pc_d = tgt;
    else if (pclw) pc_d = {pclath_q, wv};
    else pc_d = pc_q + 13'd1 + {12'd0, skip};
  end

  wire mem_wr = ex_q && wr && (addr_q[6:0] != A_INDF) && (addr_q[6:0] != A_PCL) &&
                (addr_q[6:0] != A_STATUS) && (addr_q[6:0] != A_FSR) &&
                (addr_q[6:0] != A_PCLATH) && (addr_q[6:0] != A_INTCON);

  // data store and stack memories, instruction capture and result registers
  always_ff @(posedge clk_i) begin
    if (acc) rd_q <= mem[ra];
    if (mem_wr) mem[addr_q] <= wv;
    if (ex_q && push) stk[sp_d] <= pc_q + 13'd1;
    if (acc) begin ins_q <= in_if.instruction; addr_q <= ra; end
    if (ex_q) begin opc_q <= pc_d; ow_q <= w_d; ost_q <= st_d; end
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mvld_q <= '0; svld_q <= '0; rdv_q <= 1'b0; ex_q <= 1'b0; ov_q <= 1'b0;
      w_q <= '0; status_q <= STATUS_RST; fsr_q <= '0; intcon_q <= '0;
      pclath_q <= '0; pc_q <= '0; sp_q <= '0;
    end else begin
      if (acc) rdv_q <= mvld_q[ra];
      if (mem_wr) mvld_q[addr_q] <= 1'b1;
      ex_q <= acc;
      if (ex_q) begin
        if (push) svld_q[sp_d] <= 1'b1;
        w_q <= w_d; status_q <= st_d; fsr_q <= fsr_d; intcon_q <= ic_d;
        pclath_q <= pl_d; pc_q <= pc_d; sp_q <= sp_d;
        ov_q <= 1'b1;
      end else if (out_if.ready) ov_q <= 1'b0;
    end
  end

  assign out_if.valid = ov_q;
  assign out_if.next_pc = opc_q;
  assign out_if.w_value = ow_q;
  assign out_if.status_value = ost_q;

  a_ex_after_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> ex_q) else $error("execute did not follow accept");
  a_no_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ex_q |-> !in_if.ready) else $error("accept during execute");
  a_out_after_ex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ex_q |=> out_if.valid) else $error("result missing after execute");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ex_q |-> (!ov_q || $past(out_if.ready))) else $error("result overwritten");
endmodule
`default_nettype wire
